// ===== design/ccl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the content checked lru slot cache
// no dependencies; imported by ccl_cell, content_checked_lru_slot_cache and the testbench
package ccl_pkg;

    localparam int CACHE_SLOTS_DEF = 32;
    localparam int ID_W            = 32;
    localparam int HASH_W          = 64;
    localparam int STAMP_W         = 64;
    localparam int SLOT_W          = 5;

    // request broadcast to every cell
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] hash;
    } ccl_req_t;

    // write command broadcast to every cell, qualified by each cell's select
    typedef struct packed {
        logic               tag_we;
        logic               hash_we;
        logic               stamp_we;
        logic [STAMP_W-1:0] stamp;
    } ccl_wr_t;

    // per cell lookup status
    typedef struct packed {
        logic match;
        logic diff;
    } ccl_stat_t;

endpackage

// ===== design/ccl_cell.sv =====
`timescale 1ns / 1ps
// one cache slot: tag, hash, stamp and valid bit, plus one stage of the
// oldest-stamp chain; depends on ccl_pkg
module ccl_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ccl_pkg::ccl_req_t            req,
    input  ccl_pkg::ccl_wr_t             wr,
    input  logic                         sel,
    input  logic [ccl_pkg::STAMP_W-1:0]  min_stamp_in,
    input  logic [IDX_W-1:0]             min_idx_in,
    output logic [ccl_pkg::STAMP_W-1:0]  min_stamp_out,
    output logic [IDX_W-1:0]             min_idx_out,
    output ccl_pkg::ccl_stat_t           stat
);
    import ccl_pkg::*;

    logic                valid_reg;
    logic [ID_W-1:0]     tag_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [STAMP_W-1:0]  min_stamp_reg;
    logic [IDX_W-1:0]    min_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && wr.tag_we)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.tag_we)
        begin
            tag_reg <= req.id;
        end
        if (sel && wr.hash_we)
        begin
            hash_reg <= req.hash;
        end
        if (sel && wr.stamp_we)
        begin
            stamp_reg <= wr.stamp;
        end
        // strict compare keeps the lower index on equal stamps
        if (stamp_reg < min_stamp_in)
        begin
            min_stamp_reg <= stamp_reg;
            min_idx_reg   <= IDX_W'(INDEX);
        end
        else
        begin
            min_stamp_reg <= min_stamp_in;
            min_idx_reg   <= min_idx_in;
        end
    end

    assign min_stamp_out = min_stamp_reg;
    assign min_idx_out   = min_idx_reg;
    assign stat.match    = valid_reg && (tag_reg == req.id);
    assign stat.diff     = (hash_reg != req.hash);

endmodule

// ===== design/content_checked_lru_slot_cache.sv =====
`timescale 1ns / 1ps
// content checked lru slot cache, top level; depends on ccl_pkg and ccl_cell
// a taken request passes the LOOK and PICK states before its result is registered
// a new request is taken only once the previous one has left PICK; PICK also waits on out_stall
// a miss on a full cache also waits until the oldest-stamp chain has settled
// after the last stamp write
// reset clears valid bits, fill pointer, access counter and control state
module content_checked_lru_slot_cache #(
    parameter int CACHE_SLOTS = ccl_pkg::CACHE_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ccl_pkg::ID_W-1:0]    object_id,
    input  logic [ccl_pkg::HASH_W-1:0]  content_hash,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ccl_pkg::SLOT_W-1:0]  slot,
    output logic                        hit,
    output logic                        upload
);
    import ccl_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_SLOTS);
    localparam int FILL_W = $clog2(CACHE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_PICK = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    ccl_req_t             req_reg;
    logic                 hit_reg;
    logic                 diff_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    settle_reg;
    logic [STAMP_W-1:0]   counter_reg;
    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 hit_out_reg;
    logic                 upload_reg;

    ccl_stat_t            stat   [CACHE_SLOTS];
    logic [STAMP_W-1:0]   chain_stamp [CACHE_SLOTS+1];
    logic [IDX_W-1:0]     chain_idx   [CACHE_SLOTS+1];
    logic [CACHE_SLOTS-1:0] sel;

    logic                 any_match;
    logic                 any_diff;
    logic [IDX_W-1:0]     match_idx;
    logic                 filling;
    logic                 out_free;
    logic                 go;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W+SLOT_W-1:0] wr_idx_ext;
    ccl_wr_t              wr;

    // chain head: largest stamp, index zero
    assign chain_stamp[0] = '1;
    assign chain_idx[0]   = '0;

    for (genvar g = 0; g < CACHE_SLOTS; g++)
    begin : g_cell
        ccl_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .req           (req_reg),
            .wr            (wr),
            .sel           (sel[g]),
            .min_stamp_in  (chain_stamp[g]),
            .min_idx_in    (chain_idx[g]),
            .min_stamp_out (chain_stamp[g+1]),
            .min_idx_out   (chain_idx[g+1]),
            .stat          (stat[g])
        );
        assign sel[g] = (wr_idx == IDX_W'(g));
    end

    // tags are unique among valid cells, so the match index is a plain or
    always_comb
    begin
        any_match = 1'b0;
        any_diff  = 1'b0;
        match_idx = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            any_match = any_match | stat[i].match;
            any_diff  = any_diff | (stat[i].match & stat[i].diff);
            match_idx = match_idx | ({IDX_W{stat[i].match}} & IDX_W'(i));
        end
    end

    assign filling  = (fill_reg != FILL_W'(CACHE_SLOTS));
    assign out_free = !out_valid_reg || !out_stall;
    assign go       = (state_reg == S_PICK) && out_free
                      && (hit_reg || filling || (settle_reg == '0));

    always_comb
    begin
        if (hit_reg)
        begin
            wr_idx = hit_idx_reg;
        end
        else if (filling)
        begin
            wr_idx = fill_reg[IDX_W-1:0];
        end
        else
        begin
            wr_idx = chain_idx[CACHE_SLOTS];
        end
    end

    assign wr_idx_ext  = {{SLOT_W{1'b0}}, wr_idx};
    assign wr.tag_we   = go && !hit_reg;
    assign wr.hash_we  = go && (!hit_reg || diff_reg);
    assign wr.stamp_we = go;
    assign wr.stamp    = counter_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            settle_reg    <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                counter_reg   <= counter_reg + 1'b1;
                settle_reg    <= FILL_W'(CACHE_SLOTS);
                out_valid_reg <= 1'b1;
                if (!hit_reg && filling)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else
            begin
                if (settle_reg != '0)
                begin
                    settle_reg <= settle_reg - 1'b1;
                end
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg.id   <= object_id;
            req_reg.hash <= content_hash;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg     <= any_match;
            diff_reg    <= any_diff;
            hit_idx_reg <= match_idx;
        end
        if (go)
        begin
            slot_reg    <= wr_idx_ext[SLOT_W-1:0];
            hit_out_reg <= hit_reg;
            upload_reg  <= !hit_reg || diff_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign hit       = hit_out_reg;
    assign upload    = upload_reg;

endmodule

// ===== sim/tb_content_checked_lru_slot_cache.sv =====
`timescale 1ns / 1ps
// testbench for the content checked lru slot cache: directed and random lookups
// scored against an in-bench slot predictor; depends on ccl_pkg and the cache top level
module tb_content_checked_lru_slot_cache;
    import ccl_pkg::*;

    localparam int SLOTS        = CACHE_SLOTS_DEF;
    localparam int RANDOM_REQS  = 1300;
    localparam int POOL_SIZE    = 40;
    localparam int HOT_SIZE     = 24;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 700;
    localparam int IDLE_PCT     = 6;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              upload;
    } lookup_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ID_W-1:0]   object_id = '0;
    logic [HASH_W-1:0] content_hash = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              upload;

    // predictor copy of the cache contents
    logic [ID_W-1:0]    tag_mem   [SLOTS];
    logic               valid_mem [SLOTS];
    logic [HASH_W-1:0]  hash_mem  [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    int unsigned        next_fresh;
    logic [STAMP_W-1:0] access_count;

    ccl_req_t       pending_reqs[$];
    lookup_result_t expected_results[$];
    ccl_req_t       next_req;
    lookup_result_t want;

    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_hits = 0;
    int unsigned n_rehash = 0;
    int unsigned n_evictions = 0;
    int unsigned cycle_count = 0;

    always #2 clk = ~clk;

    content_checked_lru_slot_cache dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .object_id    (object_id),
        .content_hash (content_hash),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .hit          (hit),
        .upload       (upload)
    );

    function automatic lookup_result_t predict_lookup(ccl_req_t req);
        lookup_result_t res;
        int             idx;
        bit             found;
        found = 1'b0;
        idx   = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && valid_mem[i] && tag_mem[i] == req.id)
            begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found)
        begin
            res.hit    = 1'b1;
            res.upload = (hash_mem[idx] != req.hash);
            if (res.upload)
                hash_mem[idx] = req.hash;
            n_hits++;
            if (res.upload)
                n_rehash++;
        end
        else
        begin
            if (next_fresh < SLOTS)
            begin
                idx = next_fresh;
                next_fresh++;
            end
            else
            begin
                idx = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (idx < 0 && !valid_mem[i])
                        idx = i;
                end
                if (idx < 0)
                begin
                    // least recently stamped, lowest index wins a tie
                    idx = 0;
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (stamp_mem[i] < stamp_mem[idx])
                            idx = i;
                    end
                    n_evictions++;
                end
            end
            tag_mem[idx]   = req.id;
            valid_mem[idx] = 1'b1;
            hash_mem[idx]  = req.hash;
            res.hit        = 1'b0;
            res.upload     = 1'b1;
        end
        stamp_mem[idx] = access_count;
        access_count   = access_count + 1;
        res.slot       = idx[SLOT_W-1:0];
        return res;
    endfunction

    // random idle, none inside the quiet window
    function automatic bit draw_idle(int unsigned progress);
        if (progress >= QUIET_FROM && progress < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic logic [HASH_W-1:0] random_hash();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_req(logic [ID_W-1:0] id, logic [HASH_W-1:0] hash);
        ccl_req_t r;
        r.id   = id;
        r.hash = hash;
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            n_errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_results.push_back(predict_lookup(ccl_req_t'({object_id, content_hash})));
                n_accepted++;
            end
            if (pending_reqs.size() > 0 && !draw_idle(n_accepted))
            begin
                next_req = pending_reqs.pop_front();
                in_valid     <= 1'b1;
                object_id    <= next_req.id;
                content_hash <= next_req.hash;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual slot %0d hit %0b upload %0b",
                             $time, slot, hit, upload);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("slot", 8'(want.slot), 8'(slot));
                    check_field("hit", 8'(want.hit), 8'(hit));
                    check_field("upload", 8'(want.upload), 8'(upload));
                end
            end
            out_stall <= draw_idle(n_results);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d requests pending, %0d results outstanding",
                     $time, cycle_count, pending_reqs.size(), expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [ID_W-1:0]   id_pool   [POOL_SIZE];
        logic [HASH_W-1:0] last_hash [POOL_SIZE];
        int                sel;
        int                p;
        for (int i = 0; i < SLOTS; i++)
        begin
            valid_mem[i] = 1'b0;
            tag_mem[i]   = '0;
            hash_mem[i]  = '0;
            stamp_mem[i] = '0;
        end
        next_fresh   = 0;
        access_count = '0;

        // field extremes, hits with same and changed contents
        push_req(32'h0000_0000, 64'h0000_0000_0000_0000);
        push_req(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(32'h0000_0000, 64'h0000_0000_0000_0000);
        push_req(32'h0000_0000, 64'h0000_0000_0000_0001);
        push_req(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(32'hFFFF_FFFF, 64'h0000_0000_0000_0000);
        push_req(32'h8000_0000, 64'h8000_0000_0000_0000);
        push_req(32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        push_req(32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(32'h8000_0000, 64'h0000_0000_0000_0001);
        push_req(32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
        push_req(32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5);
        push_req(32'h0000_0000, 64'h0000_0000_0000_0000);
        push_req(32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE);

        // working set larger than the cache so replacement runs, hot subset for hits
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i]   = $urandom;
            last_hash[i] = random_hash();
        end
        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            sel = $urandom_range(99);
            if (sel >= 85)
                push_req($urandom, random_hash());
            else
            begin
                if (sel < 50)
                    p = $urandom_range(HOT_SIZE - 1);
                else
                    p = $urandom_range(POOL_SIZE - 1);
                if ($urandom_range(99) >= 65)
                    last_hash[p] = random_hash();
                push_req(id_pool[p], last_hash[p]);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d hits (%0d with changed contents), %0d misses",
                 n_accepted, n_hits, n_rehash, n_accepted - n_hits);
        $display("%0d oldest-slot replacements on a full cache, %0d mismatches",
                 n_evictions, n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
